/* rtl/ipid_pkg.sv */
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared widths, register indexes and types of the incremental PID core.
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

  // Sample width of target and measured; errors carry one more bit
  localparam int SAMPLE_W = 16;
  localparam int ERR_W    = SAMPLE_W + 1;
  // e - last, and e + older - 2 * last
  localparam int DIFF_W   = ERR_W + 1;
  localparam int D2_W     = ERR_W + 2;

  localparam int GAIN_W   = 24;
  localparam int LIM_W    = 31;
  localparam int ACC_W    = 32;

  // Product widths: the unsigned gain gets a zero sign bit
  localparam int PROD_P_W = GAIN_W + 1 + DIFF_W;
  localparam int PROD_I_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W = GAIN_W + 1 + D2_W;
  // Room for the accumulator plus three terms
  localparam int SUM_W    = PROD_D_W + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]  integral_limit;
    logic [LIM_W-1:0]  output_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] last_error;
    logic signed [ERR_W-1:0] older_error;
    logic signed [ACC_W-1:0] output_accum;
  } hist_t;

endpackage

`default_nettype wire

/* rtl/ipid_if.sv */
// ----------------------------------------------------------------------------
// ipid channel interfaces
// Sample, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipid_sample_if import ipid_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic signed [SAMPLE_W-1:0] target;
  logic signed [SAMPLE_W-1:0] measured;
  logic signed [ERR_W-1:0]    error_in;

  modport source (output valid, opcode, target, measured, error_in, input ready);
  modport sink   (input valid, opcode, target, measured, error_in, output ready);
endinterface

interface ipid_result_if import ipid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface ipid_cfg_if import ipid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/ipid_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ipid_cfg_regs
// Gain and limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_cfg_regs import ipid_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  ipid_cfg_if.sink    cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_p         <= '0;
      regs.gain_i         <= '0;
      regs.gain_d         <= '0;
      regs.integral_limit <= '1;
      regs.output_limit   <= '1;
    end else if (cfg.valid) begin
      // drop writes to unknown indexes
      case (cfg_idx_t'(cfg.index))
        REG_GAIN_P:         regs.gain_p         <= cfg.data[GAIN_W-1:0];
        REG_GAIN_I:         regs.gain_i         <= cfg.data[GAIN_W-1:0];
        REG_GAIN_D:         regs.gain_d         <= cfg.data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: regs.integral_limit <= cfg.data[LIM_W-1:0];
        REG_OUTPUT_LIMIT:   regs.output_limit   <= cfg.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/ipid_datapath.sv */
// ----------------------------------------------------------------------------
// ipid_datapath
// Error selection, three gain products, clamps and the output update.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_datapath import ipid_pkg::*; (
  input  wire logic                       opcode,
  input  wire logic signed [SAMPLE_W-1:0] target,
  input  wire logic signed [SAMPLE_W-1:0] measured,
  input  wire logic signed [ERR_W-1:0]    error_in,
  input  wire cfg_t                       regs,
  input  wire hist_t                      hist,
  output logic signed [ERR_W-1:0]         err,
  output logic signed [ACC_W-1:0]         accum_next
);

  logic signed [DIFF_W-1:0]   diff_p;
  logic signed [D2_W-1:0]     diff_d;
  logic signed [GAIN_W:0]     gp_s;
  logic signed [GAIN_W:0]     gi_s;
  logic signed [GAIN_W:0]     gd_s;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [PROD_I_W-1:0] ilim_pos;
  logic signed [PROD_I_W-1:0] ilim_neg;
  logic signed [PROD_I_W-1:0] term_i;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    olim_pos;
  logic signed [SUM_W-1:0]    olim_neg;
  logic signed [SUM_W-1:0]    sum_sat;

  always_comb begin
    if (opcode) begin
      err = error_in;
    end else begin
      err = ERR_W'(target) - ERR_W'(measured);
    end
  end

  assign diff_p = DIFF_W'(err) - DIFF_W'(hist.last_error);
  assign diff_d = D2_W'(err) + D2_W'(hist.older_error) - (D2_W'(hist.last_error) <<< 1);

  assign gp_s = signed'({1'b0, regs.gain_p});
  assign gi_s = signed'({1'b0, regs.gain_i});
  assign gd_s = signed'({1'b0, regs.gain_d});

  assign prod_p = gp_s * diff_p;
  assign prod_i = gi_s * err;
  assign prod_d = gd_s * diff_d;

  // clamp the integral increment to the symmetric limit
  assign ilim_pos = signed'(PROD_I_W'(regs.integral_limit));
  assign ilim_neg = -ilim_pos;

  always_comb begin
    if (prod_i > ilim_pos) begin
      term_i = ilim_pos;
    end else if (prod_i < ilim_neg) begin
      term_i = ilim_neg;
    end else begin
      term_i = prod_i;
    end
  end

  assign sum = SUM_W'(hist.output_accum) + SUM_W'(prod_p) + SUM_W'(term_i)
             + SUM_W'(prod_d);

  assign olim_pos = signed'(SUM_W'(regs.output_limit));
  assign olim_neg = -olim_pos;

  always_comb begin
    if (sum > olim_pos) begin
      sum_sat = olim_pos;
    end else if (sum < olim_neg) begin
      sum_sat = olim_neg;
    end else begin
      sum_sat = sum;
    end
  end

  assign accum_next = sum_sat[ACC_W-1:0];

endmodule

`default_nettype wire

/* rtl/incremental_pid_controller_core.sv */
// ----------------------------------------------------------------------------
// incremental_pid_controller_core
// Velocity-form PID: adds P, clamped I and D increments to a saturated output.
// ----------------------------------------------------------------------------
//
//   channel  role   carries
//   -------  -----  ---------------------------------------------
//   sample   sink   opcode, target, measured, error_in
//   result   source drive, one per sample
//   cfg      sink   index, data (gains and limits, always ready)
//
// One sample per cycle while the result is not stalled. A sample is held in the
// input register, then the products, clamps and accumulator update land in the
// output register, written by the single multiply-add-saturate stage that
// closes the accumulator loop. Reset clears the history and output to zero,
// gains to zero and limits to full scale. A stalled result holds the output
// register; the input register keeps taking a request while it can move on.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_controller_core import ipid_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  ipid_sample_if.sink  sample,
  ipid_result_if.source result,
  ipid_cfg_if.sink     cfg
);

  cfg_t regs;
  hist_t hist;

  logic                       s1_valid;
  logic                       s1_opcode;
  logic signed [SAMPLE_W-1:0] s1_target;
  logic signed [SAMPLE_W-1:0] s1_measured;
  logic signed [ERR_W-1:0]    s1_error_in;
  logic                       s1_advance;
  logic                       out_valid;
  logic signed [ERR_W-1:0]    err;
  logic signed [ACC_W-1:0]    accum_next;

  ipid_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ipid_datapath u_dp (
    .opcode     (s1_opcode),
    .target     (s1_target),
    .measured   (s1_measured),
    .error_in   (s1_error_in),
    .regs       (regs),
    .hist       (hist),
    .err        (err),
    .accum_next (accum_next)
  );

  assign s1_advance   = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_opcode   <= sample.opcode;
      s1_target   <= sample.target;
      s1_measured <= sample.measured;
      s1_error_in <= sample.error_in;
    end
  end

  // advance the history and output together with each sample
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hist      <= '0;
    end else begin
      if (s1_advance) begin
        out_valid         <= 1'b1;
        hist.output_accum <= accum_next;
        hist.older_error  <= hist.last_error;
        hist.last_error   <= err;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.drive = hist.output_accum;

endmodule

`default_nettype wire
